@@ rtl/core/spectral_coherence_estimator_defines.svh @@
// assertion macros for the spectral coherence estimator
`ifndef SPECTRAL_COHERENCE_ESTIMATOR_DEFINES_SVH
`define SPECTRAL_COHERENCE_ESTIMATOR_DEFINES_SVH
`ifndef SYNTH
// same-cycle implication
`define SCE_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("sce assertion failed");
// next-cycle implication
`define SCE_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("sce assertion failed");
`else
`define SCE_ASSERT_NOW(lbl, ck, rn, ante, cons)
`define SCE_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

@@ rtl/core/sce_pkg.sv @@
// shared types and constants for the spectral coherence estimator
package sce_pkg;

    localparam int NUM_BINS_DEF   = 1024;
    localparam int MAX_FRAMES_DEF = 16;
    localparam int FA_W           = 5;
    localparam int STEP_W         = 8;

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [9:0]         bin;
        logic signed [15:0] ref_re;
        logic signed [15:0] ref_im;
        logic signed [15:0] meas_re;
        logic signed [15:0] meas_im;
    } in_word_t;

    typedef struct packed {
        logic [15:0] coherence;
        logic        undefined;
    } out_word_t;

    // one stored frame of one bin
    typedef struct packed {
        logic [31:0]        pr;
        logic [31:0]        pm;
        logic signed [32:0] xre;
        logic signed [32:0] xim;
    } store_word_t;

    // multiplier operations, issued in this order
    typedef enum logic [4:0] {
        MUL_RR, MUL_RI, MUL_MR, MUL_MI,
        MUL_RRMR, MUL_RIMI, MUL_RRMI, MUL_RIMR,
        MUL_DEN_LL, MUL_DEN_LH, MUL_DEN_HL, MUL_DEN_HH,
        MUL_NRE_LL, MUL_NRE_LH, MUL_NRE_HL, MUL_NRE_HH,
        MUL_NIM_LL, MUL_NIM_LH, MUL_NIM_HL, MUL_NIM_HH
    } mul_op_t;

    typedef struct packed {
        logic              load;
        logic              clr_go;
        logic              mul_go;
        mul_op_t           mul_op;
        logic              rd_go;
        logic [STEP_W-1:0] step;
        logic              mag_go;
        logic              wr_go;
        logic              div_init;
        logic              div_go;
        logic              sqrt_init;
        logic              sqrt_go;
        logic              out_load;
    } sce_cmd_t;

    typedef struct packed {
        logic            is_query;
        logic            bin_ok;
        logic            clr_last;
        logic            out_free;
        logic [FA_W-1:0] fa;
    } sce_sts_t;

endpackage

@@ rtl/core/sce_mem.sv @@
// frame store memory, one write port and one registered read port
module sce_mem #(
    parameter int DEPTH = sce_pkg::NUM_BINS_DEF * sce_pkg::MAX_FRAMES_DEF,
    parameter int AW    = $clog2(sce_pkg::NUM_BINS_DEF * sce_pkg::MAX_FRAMES_DEF)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [AW-1:0]        waddr,
    input  sce_pkg::store_word_t wdata,
    input  logic                 re,
    input  logic [AW-1:0]        raddr,
    output sce_pkg::store_word_t rdata
);

    sce_pkg::store_word_t mem [DEPTH];
    sce_pkg::store_word_t rdata_reg;

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/sce_ctrl.sv @@
// sequencing state machine for the spectral coherence estimator
`include "spectral_coherence_estimator_defines.svh"
module sce_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              cfg_we,
    input  sce_pkg::sce_sts_t sts,
    output sce_pkg::sce_cmd_t cmd,
    output logic              in_stall
);

    localparam int DIV_STEPS  = 33;
    localparam int SQRT_STEPS = 16;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_APP_MUL, S_APP_DRAIN, S_APP_WR,
        S_Q_READ, S_Q_RDRAIN, S_Q_MAG, S_Q_WIDE, S_Q_WDRAIN,
        S_Q_DIVI, S_Q_DIV, S_Q_SQI, S_Q_SQ, S_Q_OUT
    } state_t;

    state_t                         state_reg;
    sce_pkg::mul_op_t               op_reg;
    logic [sce_pkg::STEP_W-1:0]     step_reg;
    logic [sce_pkg::STEP_W:0]       step_inc;

    assign step_inc = {1'b0, step_reg} + 1'b1;

    // state, operation and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            op_reg    <= sce_pkg::MUL_RR;
            step_reg  <= '0;
        end
        else if (cfg_we)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    if (sts.clr_last)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    step_reg <= '0;
                    op_reg   <= sce_pkg::MUL_RR;
                    if (!sts.is_query)
                    begin
                        state_reg <= S_APP_MUL;
                    end
                    else if (!sts.bin_ok)
                    begin
                        state_reg <= S_Q_OUT;
                    end
                    else
                    begin
                        state_reg <= S_Q_READ;
                    end
                end
                S_APP_MUL:
                begin
                    op_reg <= sce_pkg::mul_op_t'(op_reg + 5'd1);
                    if (op_reg == sce_pkg::MUL_RIMR)
                    begin
                        state_reg <= S_APP_DRAIN;
                    end
                end
                S_APP_DRAIN: state_reg <= S_APP_WR;
                S_APP_WR:    state_reg <= S_IDLE;
                S_Q_READ:
                begin
                    step_reg <= step_inc[sce_pkg::STEP_W-1:0];
                    if (step_inc >= (sce_pkg::STEP_W+1)'(sts.fa))
                    begin
                        state_reg <= S_Q_RDRAIN;
                    end
                end
                S_Q_RDRAIN: state_reg <= S_Q_MAG;
                S_Q_MAG:
                begin
                    op_reg    <= sce_pkg::MUL_DEN_LL;
                    state_reg <= S_Q_WIDE;
                end
                S_Q_WIDE:
                begin
                    op_reg <= sce_pkg::mul_op_t'(op_reg + 5'd1);
                    if (op_reg == sce_pkg::MUL_NIM_HH)
                    begin
                        state_reg <= S_Q_WDRAIN;
                    end
                end
                S_Q_WDRAIN: state_reg <= S_Q_DIVI;
                S_Q_DIVI:
                begin
                    step_reg  <= '0;
                    state_reg <= S_Q_DIV;
                end
                S_Q_DIV:
                begin
                    step_reg <= step_inc[sce_pkg::STEP_W-1:0];
                    if (step_reg == sce_pkg::STEP_W'(DIV_STEPS - 1))
                    begin
                        state_reg <= S_Q_SQI;
                    end
                end
                S_Q_SQI:
                begin
                    step_reg  <= '0;
                    state_reg <= S_Q_SQ;
                end
                S_Q_SQ:
                begin
                    step_reg <= step_inc[sce_pkg::STEP_W-1:0];
                    if (step_reg == sce_pkg::STEP_W'(SQRT_STEPS - 1))
                    begin
                        state_reg <= S_Q_OUT;
                    end
                end
                S_Q_OUT:
                begin
                    if (sts.out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_CLEAR;
            endcase
        end
    end

    // commands to the datapath
    always_comb
    begin
        cmd           = '0;
        cmd.load      = (state_reg == S_IDLE) && in_valid;
        cmd.clr_go    = (state_reg == S_CLEAR);
        cmd.mul_go    = (state_reg == S_APP_MUL) || (state_reg == S_Q_WIDE);
        cmd.mul_op    = op_reg;
        cmd.rd_go     = (state_reg == S_Q_READ);
        cmd.step      = step_reg;
        cmd.mag_go    = (state_reg == S_Q_MAG);
        cmd.wr_go     = (state_reg == S_APP_WR);
        cmd.div_init  = (state_reg == S_Q_DIVI);
        cmd.div_go    = (state_reg == S_Q_DIV);
        cmd.sqrt_init = (state_reg == S_Q_SQI);
        cmd.sqrt_go   = (state_reg == S_Q_SQ);
        cmd.out_load  = (state_reg == S_Q_OUT) && sts.out_free;
    end

    assign in_stall = (state_reg != S_IDLE);

    `SCE_ASSERT_NEXT(a_cfg_clears, clk, rst_n, cfg_we, state_reg == S_CLEAR)
    `SCE_ASSERT_NOW(a_one_unit, clk, rst_n, cmd.mul_go, !cmd.rd_go && !cmd.wr_go)
    `SCE_ASSERT_NEXT(a_load_busy, clk, rst_n, cmd.load && !cfg_we, in_stall)

endmodule

@@ rtl/core/sce_dp.sv @@
// datapath: powers and cross terms, bin sums, wide products, divider and root
`include "spectral_coherence_estimator_defines.svh"
module sce_dp #(
    parameter int NUM_BINS   = sce_pkg::NUM_BINS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  sce_pkg::in_word_t         in_data,
    input  logic                      cfg_we,
    input  logic [sce_pkg::FA_W-1:0]  cfg_data,
    input  sce_pkg::sce_cmd_t         cmd,
    output sce_pkg::sce_sts_t         sts,
    output logic                      out_valid,
    input  logic                      out_stall,
    output sce_pkg::out_word_t        out_data,
    output logic                      mem_we,
    output logic [$clog2(NUM_BINS*sce_pkg::MAX_FRAMES_DEF > 1 ?
                         NUM_BINS*sce_pkg::MAX_FRAMES_DEF : 2)-1:0] mem_waddr,
    output sce_pkg::store_word_t      mem_wdata,
    output logic                      mem_re,
    output logic [$clog2(NUM_BINS*sce_pkg::MAX_FRAMES_DEF > 1 ?
                         NUM_BINS*sce_pkg::MAX_FRAMES_DEF : 2)-1:0] mem_raddr,
    input  sce_pkg::store_word_t      mem_rdata
);

    localparam int MAX_FRAMES = sce_pkg::MAX_FRAMES_DEF;
    localparam int DEPTH = NUM_BINS * MAX_FRAMES;
    localparam int AW    = $clog2(DEPTH > 1 ? DEPTH : 2);
    localparam int SW    = MAX_FRAMES > 1 ? $clog2(MAX_FRAMES) : 1;

    sce_pkg::in_word_t            item_reg;
    logic                         bin_ok_reg;
    logic [sce_pkg::FA_W-1:0]     fa_reg, fa_next;
    logic [SW-1:0]                slot_reg, slot_next;
    logic [AW-1:0]                clr_cnt_reg, base;

    // multiplier
    logic signed [18:0]           mul_a, mul_b;
    logic signed [37:0]           prod_reg;
    sce_pkg::mul_op_t             op_d_reg;
    logic                         pv_reg;
    logic [72:0]                  wide_term;

    // append terms
    logic [31:0]                  pw_r_reg, pw_m_reg;
    logic signed [32:0]           xre_reg, xim_reg;

    // query sums and products
    logic                         rd_v_reg;
    logic [35:0]                  prr_reg, pmm_reg, mag_re_reg, mag_im_reg;
    logic signed [36:0]           cre_reg, cim_reg;
    logic [71:0]                  den_reg;
    logic [72:0]                  num_reg;

    // divider and root
    logic [71:0]                  rem_reg;
    logic [32:0]                  dlo_reg;
    logic                         sat_reg;
    logic [72:0]                  div_r;
    logic                         div_ge;
    logic [31:0]                  sx_reg;
    logic [17:0]                  srem_reg;
    logic [15:0]                  root_reg;
    logic [19:0]                  sq_r, sq_t;
    logic                         sq_ge;

    logic                         out_valid_reg;
    sce_pkg::out_word_t           out_data_reg;
    logic                         undef;

    assign base = AW'(32'(item_reg.bin) * MAX_FRAMES);

    // next frame slot and effective depth
    always_comb
    begin
        if (32'(slot_reg) + 32'd1 >= 32'(fa_reg))
        begin
            slot_next = '0;
        end
        else
        begin
            slot_next = slot_reg + 1'b1;
        end
        if (cfg_data == '0)
        begin
            fa_next = sce_pkg::FA_W'(1);
        end
        else if (32'(cfg_data) > MAX_FRAMES)
        begin
            fa_next = sce_pkg::FA_W'(MAX_FRAMES);
        end
        else
        begin
            fa_next = cfg_data;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fa_reg        <= sce_pkg::FA_W'(1);
            slot_reg      <= '0;
            clr_cnt_reg   <= '0;
            pv_reg        <= 1'b0;
            rd_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pv_reg   <= cmd.mul_go;
            rd_v_reg <= cmd.rd_go;
            if (cfg_we)
            begin
                fa_reg      <= fa_next;
                slot_reg    <= '0;
                clr_cnt_reg <= '0;
            end
            else
            begin
                if (cmd.clr_go)
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                end
                if (cmd.load && in_data.cmd == sce_pkg::CMD_APPEND && in_data.bin == '0)
                begin
                    slot_reg <= slot_next;
                end
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.mul_op)
            sce_pkg::MUL_RR:     begin mul_a = 19'(item_reg.ref_re);  mul_b = 19'(item_reg.ref_re);  end
            sce_pkg::MUL_RI:     begin mul_a = 19'(item_reg.ref_im);  mul_b = 19'(item_reg.ref_im);  end
            sce_pkg::MUL_MR:     begin mul_a = 19'(item_reg.meas_re); mul_b = 19'(item_reg.meas_re); end
            sce_pkg::MUL_MI:     begin mul_a = 19'(item_reg.meas_im); mul_b = 19'(item_reg.meas_im); end
            sce_pkg::MUL_RRMR:   begin mul_a = 19'(item_reg.ref_re);  mul_b = 19'(item_reg.meas_re); end
            sce_pkg::MUL_RIMI:   begin mul_a = 19'(item_reg.ref_im);  mul_b = 19'(item_reg.meas_im); end
            sce_pkg::MUL_RRMI:   begin mul_a = 19'(item_reg.ref_re);  mul_b = 19'(item_reg.meas_im); end
            sce_pkg::MUL_RIMR:   begin mul_a = 19'(item_reg.ref_im);  mul_b = 19'(item_reg.meas_re); end
            sce_pkg::MUL_DEN_LL: begin mul_a = $signed({1'b0, prr_reg[17:0]});  mul_b = $signed({1'b0, pmm_reg[17:0]});  end
            sce_pkg::MUL_DEN_LH: begin mul_a = $signed({1'b0, prr_reg[17:0]});  mul_b = $signed({1'b0, pmm_reg[35:18]}); end
            sce_pkg::MUL_DEN_HL: begin mul_a = $signed({1'b0, prr_reg[35:18]}); mul_b = $signed({1'b0, pmm_reg[17:0]});  end
            sce_pkg::MUL_DEN_HH: begin mul_a = $signed({1'b0, prr_reg[35:18]}); mul_b = $signed({1'b0, pmm_reg[35:18]}); end
            sce_pkg::MUL_NRE_LL: begin mul_a = $signed({1'b0, mag_re_reg[17:0]});  mul_b = $signed({1'b0, mag_re_reg[17:0]});  end
            sce_pkg::MUL_NRE_LH: begin mul_a = $signed({1'b0, mag_re_reg[17:0]});  mul_b = $signed({1'b0, mag_re_reg[35:18]}); end
            sce_pkg::MUL_NRE_HL: begin mul_a = $signed({1'b0, mag_re_reg[35:18]}); mul_b = $signed({1'b0, mag_re_reg[17:0]});  end
            sce_pkg::MUL_NRE_HH: begin mul_a = $signed({1'b0, mag_re_reg[35:18]}); mul_b = $signed({1'b0, mag_re_reg[35:18]}); end
            sce_pkg::MUL_NIM_LL: begin mul_a = $signed({1'b0, mag_im_reg[17:0]});  mul_b = $signed({1'b0, mag_im_reg[17:0]});  end
            sce_pkg::MUL_NIM_LH: begin mul_a = $signed({1'b0, mag_im_reg[17:0]});  mul_b = $signed({1'b0, mag_im_reg[35:18]}); end
            sce_pkg::MUL_NIM_HL: begin mul_a = $signed({1'b0, mag_im_reg[35:18]}); mul_b = $signed({1'b0, mag_im_reg[17:0]});  end
            sce_pkg::MUL_NIM_HH: begin mul_a = $signed({1'b0, mag_im_reg[35:18]}); mul_b = $signed({1'b0, mag_im_reg[35:18]}); end
            default:             begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // partial product placement
    always_comb
    begin
        unique case (op_d_reg) inside
            sce_pkg::MUL_DEN_LH, sce_pkg::MUL_DEN_HL, sce_pkg::MUL_NRE_LH,
            sce_pkg::MUL_NRE_HL, sce_pkg::MUL_NIM_LH, sce_pkg::MUL_NIM_HL:
                wide_term = 73'(prod_reg[35:0]) << 18;
            sce_pkg::MUL_DEN_HH, sce_pkg::MUL_NRE_HH, sce_pkg::MUL_NIM_HH:
                wide_term = 73'(prod_reg[35:0]) << 36;
            default:
                wide_term = 73'(prod_reg[35:0]);
        endcase
    end

    // divider and root step logic
    always_comb
    begin
        div_r  = {rem_reg, dlo_reg[32]};
        div_ge = div_r >= {1'b0, den_reg};
        sq_r   = {srem_reg, sx_reg[31:30]};
        sq_t   = {2'b00, root_reg, 2'b01};
        sq_ge  = sq_r >= sq_t;
    end

    assign undef = !bin_ok_reg || prr_reg == '0 || pmm_reg == '0;

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg   <= in_data;
            bin_ok_reg <= 32'(in_data.bin) < NUM_BINS;
            pw_r_reg   <= '0;
            pw_m_reg   <= '0;
            xre_reg    <= '0;
            xim_reg    <= '0;
            prr_reg    <= '0;
            pmm_reg    <= '0;
            cre_reg    <= '0;
            cim_reg    <= '0;
        end
        // one product a cycle
        if (cmd.mul_go)
        begin
            prod_reg <= mul_a * mul_b;
            op_d_reg <= cmd.mul_op;
        end
        // accumulate the previous product
        if (pv_reg)
        begin
            unique case (op_d_reg) inside
                sce_pkg::MUL_RR, sce_pkg::MUL_RI:
                    pw_r_reg <= pw_r_reg + prod_reg[31:0];
                sce_pkg::MUL_MR, sce_pkg::MUL_MI:
                    pw_m_reg <= pw_m_reg + prod_reg[31:0];
                sce_pkg::MUL_RRMR, sce_pkg::MUL_RIMI:
                    xre_reg <= xre_reg + $signed(prod_reg[32:0]);
                sce_pkg::MUL_RRMI:
                    xim_reg <= xim_reg + $signed(prod_reg[32:0]);
                sce_pkg::MUL_RIMR:
                    xim_reg <= xim_reg - $signed(prod_reg[32:0]);
                sce_pkg::MUL_DEN_LL, sce_pkg::MUL_DEN_LH,
                sce_pkg::MUL_DEN_HL, sce_pkg::MUL_DEN_HH:
                    den_reg <= den_reg + wide_term[71:0];
                default:
                    num_reg <= num_reg + wide_term;
            endcase
        end
        // bin sums over the stored frames
        if (rd_v_reg)
        begin
            prr_reg <= prr_reg + 36'(mem_rdata.pr);
            pmm_reg <= pmm_reg + 36'(mem_rdata.pm);
            cre_reg <= cre_reg + 37'(mem_rdata.xre);
            cim_reg <= cim_reg + 37'(mem_rdata.xim);
        end
        // magnitudes of the cross sums
        if (cmd.mag_go)
        begin
            mag_re_reg <= cre_reg < 0 ? 36'(-cre_reg) : 36'(cre_reg);
            mag_im_reg <= cim_reg < 0 ? 36'(-cim_reg) : 36'(cim_reg);
            den_reg    <= '0;
            num_reg    <= '0;
        end
        // restoring division of num * 2^32 by den
        if (cmd.div_init)
        begin
            rem_reg <= num_reg[72:1];
            dlo_reg <= {num_reg[0], 32'd0};
            sat_reg <= num_reg[72:1] >= den_reg;
        end
        else if (cmd.div_go)
        begin
            rem_reg <= div_ge ? 72'(div_r - {1'b0, den_reg}) : div_r[71:0];
            dlo_reg <= {dlo_reg[31:0], div_ge};
        end
        // integer square root of the clamped quotient
        if (cmd.sqrt_init)
        begin
            sx_reg   <= (sat_reg || dlo_reg[32]) ? '1 : dlo_reg[31:0];
            srem_reg <= '0;
            root_reg <= '0;
        end
        else if (cmd.sqrt_go)
        begin
            srem_reg <= sq_ge ? 18'(sq_r - sq_t) : sq_r[17:0];
            root_reg <= {root_reg[14:0], sq_ge};
            sx_reg   <= sx_reg << 2;
        end
        // result word
        if (cmd.out_load)
        begin
            out_data_reg.coherence <= undef ? '0 : root_reg;
            out_data_reg.undefined <= undef;
        end
    end

    // memory ports
    always_comb
    begin
        mem_we    = cmd.clr_go || (cmd.wr_go && bin_ok_reg);
        mem_waddr = cmd.clr_go ? clr_cnt_reg : base + AW'(slot_reg);
        mem_wdata = '0;
        if (!cmd.clr_go)
        begin
            mem_wdata.pr  = pw_r_reg;
            mem_wdata.pm  = pw_m_reg;
            mem_wdata.xre = xre_reg;
            mem_wdata.xim = xim_reg;
        end
        mem_re    = cmd.rd_go;
        mem_raddr = base + AW'(cmd.step);
    end

    // status to the controller
    always_comb
    begin
        sts.is_query = (item_reg.cmd == sce_pkg::CMD_QUERY);
        sts.bin_ok   = bin_ok_reg;
        sts.clr_last = (clr_cnt_reg == AW'(DEPTH - 1));
        sts.out_free = !out_valid_reg || !out_stall;
        sts.fa       = fa_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `SCE_ASSERT_NOW(a_out_free, clk, rst_n, cmd.out_load, !out_valid_reg || !out_stall)
    `SCE_ASSERT_NOW(a_clr_alone, clk, rst_n, cmd.clr_go, !cmd.wr_go && !cmd.rd_go)
    `SCE_ASSERT_NEXT(a_rd_valid, clk, rst_n, cmd.rd_go, rd_v_reg)

endmodule

@@ rtl/core/spectral_coherence_estimator.sv @@
// top level of the spectral coherence estimator
//
//  channel  direction  handshake         word
//  in       input      in_valid/in_stall  in_word_t: cmd, bin, spectra
//  cfg      input      cfg_valid/ready    frames_averaged, 5 bits
//  out      output     out_valid/out_stall out_word_t: coherence, undefined
//
// an append: one multiplier forms eight 16x16 products in turn
// a query has one memory read per frame, twelve
//   18x18 partial products, a 33-step restoring divider and a 16-step root
// after reset and after every cfg write a clearing pass zeroes all
//   NUM_BINS*MAX_FRAMES entries of the frame store; no item is taken meanwhile
// a result waits in the output register while out_stall is high; the next item is
//   already taken, and a query is held at its final step until the register frees
module spectral_coherence_estimator #(
    parameter int NUM_BINS   = sce_pkg::NUM_BINS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  sce_pkg::in_word_t        in_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [sce_pkg::FA_W-1:0] cfg_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output sce_pkg::out_word_t       out_data
);

    localparam int DEPTH = NUM_BINS * sce_pkg::MAX_FRAMES_DEF;
    localparam int AW    = $clog2(DEPTH > 1 ? DEPTH : 2);

    sce_pkg::sce_cmd_t    cmd;
    sce_pkg::sce_sts_t    sts;
    logic                 cfg_we;
    logic                 mem_we, mem_re;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    sce_pkg::store_word_t mem_wdata, mem_rdata;

    // configuration is always taken
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    sce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cfg_we   (cfg_we),
        .sts      (sts),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    sce_dp #(
        .NUM_BINS   (NUM_BINS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    sce_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule
